@@ hdl/pwmicm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmicm_pkg
// Shared types and constants of the PWM input capture and measure block.
// ----------------------------------------------------------------------------
package pwmicm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int PRE_BITS   = 16;
  localparam int LIMIT_BITS = 16;
  localparam int RATE_BITS  = 24;
  localparam int SCALE_BITS = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // divisor is capture + 1, one bit wider than the capture
  localparam int DVS_BITS   = COUNT_BITS + 1;
  // dividend of the duty division: (high + 1) * scale
  localparam int DVD_BITS   = DVS_BITS + SCALE_BITS;
  localparam int STEP_BITS  = $clog2(DVD_BITS + 1);

  localparam logic [PRE_BITS-1:0]   TICK_DIVIDER_RST   = PRE_BITS'(72 - 1);
  localparam logic [LIMIT_BITS-1:0] PERIOD_LIMIT_RST   = LIMIT_BITS'(65536 - 1);
  localparam logic [RATE_BITS-1:0]  REFERENCE_RATE_RST = RATE_BITS'(1000000);
  localparam logic [SCALE_BITS-1:0] DUTY_SCALE_RST     = SCALE_BITS'(1000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE         = 3'd0,
    REG_TICK_DIVIDER   = 3'd1,
    REG_PERIOD_LIMIT   = 3'd2,
    REG_REFERENCE_RATE = 3'd3,
    REG_DUTY_SCALE     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    func_e func;
    logic  pin_level;
  } in_item_t;

  typedef struct packed {
    logic [RATE_BITS-1:0]  frequency;
    logic [SCALE_BITS-1:0] duty;
  } out_item_t;

  typedef struct packed {
    logic                  enable;
    logic [PRE_BITS-1:0]   tick_divider;
    logic [LIMIT_BITS-1:0] period_limit;
    logic [RATE_BITS-1:0]  reference_rate;
    logic [SCALE_BITS-1:0] duty_scale;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] period;
    logic [COUNT_BITS-1:0] high;
  } meas_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/pwm_input_capture_measure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_input_capture_measure
// PWM input measurement timer: period and high-time capture, frequency and
// duty reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): tick items carry a
//   pin sample; read items request a measurement. Ticks produce no result.
//   An enabled read produces one result on the output channel
//   (out_valid_o / out_stall_i / out_data_o); a disabled read produces none.
//   Ticks are taken one per cycle while the queue is not full. An enabled
//   read posts a capture snapshot to a two-entry queue; in_stall_o is high
//   only while that queue is full. An accepted read passes through the
//   queue, a multiply state, bit-serial division (frequency and duty
//   dividers run side by side) and the output register. One snapshot is
//   worked on at a time; further reads wait in the queue.
//   A stalled result stays in the output register; the divider holds its
//   finished value behind it, and ticks keep flowing until the queue fills.
//   Reset clears counters and captures and loads the register defaults
//   (disabled, divider 71, limit 65535, rate 1000000, scale 1000).
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_input_capture_measure (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pwmicm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pwmicm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  pwmicm_pkg::in_item_t                   in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output pwmicm_pkg::out_item_t                  out_data_o
);

  pwmicm_pkg::cfg_t      cfg_q;
  pwmicm_pkg::q_status_t q_status;
  pwmicm_pkg::meas_t     push_data;
  pwmicm_pkg::meas_t     head;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.tick_divider   <= pwmicm_pkg::TICK_DIVIDER_RST;
      cfg_q.period_limit   <= pwmicm_pkg::PERIOD_LIMIT_RST;
      cfg_q.reference_rate <= pwmicm_pkg::REFERENCE_RATE_RST;
      cfg_q.duty_scale     <= pwmicm_pkg::DUTY_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwmicm_pkg::REG_ENABLE: begin
          cfg_q.enable <= cfg_wdata_i[0];
        end
        pwmicm_pkg::REG_TICK_DIVIDER: begin
          cfg_q.tick_divider <= cfg_wdata_i[pwmicm_pkg::PRE_BITS-1:0];
        end
        pwmicm_pkg::REG_PERIOD_LIMIT: begin
          cfg_q.period_limit <= cfg_wdata_i[pwmicm_pkg::LIMIT_BITS-1:0];
        end
        pwmicm_pkg::REG_REFERENCE_RATE: begin
          cfg_q.reference_rate <= cfg_wdata_i[pwmicm_pkg::RATE_BITS-1:0];
        end
        pwmicm_pkg::REG_DUTY_SCALE: begin
          cfg_q.duty_scale <= cfg_wdata_i[pwmicm_pkg::SCALE_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  pwmicm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pwmicm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  pwmicm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/pwmicm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmicm_front
// Input side: prescaler, wrapping tick counter, edge captures; enabled reads
// post a snapshot of the captures to the queue and clear them.
// ----------------------------------------------------------------------------
module pwmicm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwmicm_pkg::cfg_t     cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pwmicm_pkg::in_item_t in_data_i,
  input  pwmicm_pkg::q_status_t q_status_i,
  output logic                 push_o,
  output pwmicm_pkg::meas_t    push_data_o
);

  logic [pwmicm_pkg::PRE_BITS-1:0]   pre_q, pre_d;
  logic [pwmicm_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [pwmicm_pkg::COUNT_BITS-1:0] period_q, period_d;
  logic [pwmicm_pkg::COUNT_BITS-1:0] high_q, high_d;
  logic                              prev_q, prev_d;
  logic                              accept;

  assign in_stall_o  = q_status_i.full;
  assign accept      = in_valid_i & ~in_stall_o;
  assign push_o      = accept & (in_data_i.func == pwmicm_pkg::FUNC_READ) & cfg_i.enable;
  assign push_data_o = '{period: period_q, high: high_q};

  always_comb begin
    pre_d    = pre_q;
    cnt_d    = cnt_q;
    period_d = period_q;
    high_d   = high_q;
    prev_d   = prev_q;
    if (accept) begin
      if (in_data_i.func == pwmicm_pkg::FUNC_TICK) begin
        prev_d = in_data_i.pin_level;
        if (cfg_i.enable) begin
          if (in_data_i.pin_level && !prev_q) begin
            period_d = cnt_q;
            cnt_d    = '0;
            pre_d    = '0;
          end else begin
            if (!in_data_i.pin_level && prev_q) begin
              high_d = cnt_q;
            end
            if (pre_q >= cfg_i.tick_divider) begin
              pre_d = '0;
              if (32'(cnt_q) >= 32'(cfg_i.period_limit)) begin
                cnt_d = '0;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              pre_d = pre_q + 1'b1;
            end
          end
        end
      end else if (cfg_i.enable) begin
        period_d = '0;
        high_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q    <= '0;
      cnt_q    <= '0;
      period_q <= '0;
      high_q   <= '0;
      prev_q   <= 1'b0;
    end else begin
      pre_q    <= pre_d;
      cnt_q    <= cnt_d;
      period_q <= period_d;
      high_q   <= high_d;
      prev_q   <= prev_d;
    end
  end

endmodule

@@ hdl/pwmicm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmicm_queue
// Two-entry queue of capture snapshots between front and back.
// ----------------------------------------------------------------------------
module pwmicm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pwmicm_pkg::meas_t     push_data_i,
  input  logic                  pop_i,
  output pwmicm_pkg::meas_t     head_o,
  output pwmicm_pkg::q_status_t status_o
);

  pwmicm_pkg::meas_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/pwmicm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmicm_back
// Result side: duty product, two restoring dividers stepped one bit per
// cycle, result fix-up and output register.
// ----------------------------------------------------------------------------
module pwmicm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwmicm_pkg::cfg_t      cfg_i,
  input  pwmicm_pkg::q_status_t q_status_i,
  input  pwmicm_pkg::meas_t     head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pwmicm_pkg::out_item_t out_data_o
);

  localparam int DVS = pwmicm_pkg::DVS_BITS;
  localparam int DVD = pwmicm_pkg::DVD_BITS;
  localparam int SB  = pwmicm_pkg::STEP_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [DVS-1:0]         dvs_q, dvs_d;
  logic [DVS-1:0]         hp1_q, hp1_d;
  logic [DVD-1:0]         dvd_f_q, dvd_f_d;
  logic [DVD-1:0]         dvd_d_q, dvd_d_d;
  logic [DVS-1:0]         rem_f_q, rem_f_d;
  logic [DVS-1:0]         rem_d_q, rem_d_d;
  logic [SB-1:0]          step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  pwmicm_pkg::out_item_t  out_q, out_d;

  logic [DVS:0]           t_f, t_d;
  logic                   ge_f, ge_d;
  logic [pwmicm_pkg::RATE_BITS-1:0]  freq;
  logic [pwmicm_pkg::SCALE_BITS-1:0] duty;
  logic                   out_free;

  assign pop_o       = (state_q == ST_IDLE) & ~q_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  assign t_f  = {rem_f_q, dvd_f_q[DVD-1]};
  assign t_d  = {rem_d_q, dvd_d_q[DVD-1]};
  assign ge_f = (t_f >= {1'b0, dvs_q});
  assign ge_d = (t_d >= {1'b0, dvs_q});

  always_comb begin
    freq = dvd_f_q[pwmicm_pkg::RATE_BITS-1:0];
    if (freq == cfg_i.reference_rate) begin
      freq = '0;
    end
    if (dvd_d_q == DVD'(cfg_i.duty_scale)) begin
      duty = '0;
    end else if (dvd_d_q > DVD'(cfg_i.duty_scale)) begin
      duty = cfg_i.duty_scale;
    end else begin
      duty = dvd_d_q[pwmicm_pkg::SCALE_BITS-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    dvs_d       = dvs_q;
    hp1_d       = hp1_q;
    dvd_f_d     = dvd_f_q;
    dvd_d_d     = dvd_d_q;
    rem_f_d     = rem_f_q;
    rem_d_d     = rem_d_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          dvs_d   = DVS'(head_i.period) + 1'b1;
          hp1_d   = DVS'(head_i.high) + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        dvd_d_d = hp1_q * cfg_i.duty_scale;
        dvd_f_d = DVD'(cfg_i.reference_rate);
        rem_f_d = '0;
        rem_d_d = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dvd_f_d = {dvd_f_q[DVD-2:0], ge_f};
        dvd_d_d = {dvd_d_q[DVD-2:0], ge_d};
        rem_f_d = ge_f ? DVS'(t_f - {1'b0, dvs_q}) : t_f[DVS-1:0];
        rem_d_d = ge_d ? DVS'(t_d - {1'b0, dvs_q}) : t_d[DVS-1:0];
        step_d  = step_q + 1'b1;
        if (step_q == SB'(DVD - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{frequency: freq, duty: duty};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q   <= dvs_d;
    hp1_q   <= hp1_d;
    dvd_f_q <= dvd_f_d;
    dvd_d_q <= dvd_d_d;
    rem_f_q <= rem_f_d;
    rem_d_q <= rem_d_d;
    out_q   <= out_d;
  end

endmodule

@@ verif/pwm_input_capture_measure_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_input_capture_measure_checker
// Watches the register port and both item channels of the PWM measure block.
// Keeps its own copy of the capture timer and of the registers, predicts the
// frequency and duty of every enabled read, and compares each result with the
// oldest predicted reading.
// ----------------------------------------------------------------------------
module pwm_input_capture_measure_checker
  import pwmicm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  in_item_t                 in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  out_item_t                out_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  cfg_t                  regs;
  logic [PRE_BITS-1:0]   pre_cnt;
  logic [COUNT_BITS-1:0] edge_cnt;
  logic [COUNT_BITS-1:0] period_cap;
  logic [COUNT_BITS-1:0] high_cap;
  logic                  prev_lvl;
  out_item_t             expected_readings[$];
  int                    fails = 0;

  assign fail_count_o = fails;

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic timer_step(input in_item_t it);
    logic        prev;
    logic [63:0] divisor;
    logic [63:0] freq;
    logic [63:0] duty;
    out_item_t   reading;
    if (it.func == FUNC_TICK) begin
      prev     = prev_lvl;
      prev_lvl = it.pin_level;
      if (!regs.enable) return;
      if (it.pin_level && !prev) begin
        period_cap = edge_cnt;
        edge_cnt   = '0;
        pre_cnt    = '0;
        return;
      end
      if (!it.pin_level && prev) high_cap = edge_cnt;
      if (pre_cnt >= regs.tick_divider) begin
        pre_cnt = '0;
        if (edge_cnt >= regs.period_limit) edge_cnt = '0;
        else edge_cnt = edge_cnt + 1'b1;
      end else begin
        pre_cnt = pre_cnt + 1'b1;
      end
    end else begin
      if (!regs.enable) return;
      divisor = period_cap + 64'd1;
      freq    = regs.reference_rate / divisor;
      duty    = (high_cap + 64'd1) * regs.duty_scale / divisor;
      if (freq == regs.reference_rate) freq = '0;
      if (duty == regs.duty_scale) duty = '0;
      else if (duty > regs.duty_scale) duty = regs.duty_scale;
      reading.frequency = freq[RATE_BITS-1:0];
      reading.duty      = duty[SCALE_BITS-1:0];
      expected_readings.push_back(reading);
      period_cap = '0;
      high_cap   = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      regs.enable         = 1'b0;
      regs.tick_divider   = TICK_DIVIDER_RST;
      regs.period_limit   = PERIOD_LIMIT_RST;
      regs.reference_rate = REFERENCE_RATE_RST;
      regs.duty_scale     = DUTY_SCALE_RST;
      pre_cnt    = '0;
      edge_cnt   = '0;
      period_cap = '0;
      high_cap   = '0;
      prev_lvl   = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:         regs.enable         = cfg_wdata_i[0];
          REG_TICK_DIVIDER:   regs.tick_divider   = cfg_wdata_i[PRE_BITS-1:0];
          REG_PERIOD_LIMIT:   regs.period_limit   = cfg_wdata_i[LIMIT_BITS-1:0];
          REG_REFERENCE_RATE: regs.reference_rate = cfg_wdata_i[RATE_BITS-1:0];
          REG_DUTY_SCALE:     regs.duty_scale     = cfg_wdata_i[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) timer_step(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          note_failure($sformatf("unexpected result: frequency %0d duty %0d",
                                 out_data_i.frequency, out_data_i.duty));
        end else begin
          want = expected_readings.pop_front();
          if (out_data_i.frequency !== want.frequency)
            note_failure($sformatf("frequency mismatch: expected %0d, got %0d",
                                   want.frequency, out_data_i.frequency));
          if (out_data_i.duty !== want.duty)
            note_failure($sformatf("duty mismatch: expected %0d, got %0d",
                                   want.duty, out_data_i.duty));
        end
      end
    end
    pending_o <= expected_readings.size();
  end

endmodule

@@ verif/pwm_input_capture_measure_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_input_capture_measure_tb
// Drives the PWM measure block with pin-sample ticks and read requests under
// a series of register settings, from a short directed sequence to random
// PWM waveforms, noise and read bursts, with random idling on both sides.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module pwm_input_capture_measure_tb;
  import pwmicm_pkg::*;

  localparam int HANG_LIMIT = 3000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  in_item_t                 in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_item_t                out_data_o;

  int   failures;
  int   pending;
  int   items_sent = 0;
  int   reads_live = 0;
  int   hang_cnt   = 0;
  bit   calm       = 1'b0;
  cfg_t active;

  always #5 clk_i = ~clk_i;

  pwm_input_capture_measure dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pwm_input_capture_measure_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        hang_cnt <= 0;
      end else if (hang_cnt >= HANG_LIMIT) begin
        $display("pwm_input_capture_measure_tb NOT OK");
        $finish;
      end else begin
        hang_cnt <= hang_cnt + 1;
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (it.func == FUNC_READ && active.enable) reads_live++;
  endtask

  task automatic tick(input logic lvl);
    send_item('{func: FUNC_TICK, pin_level: lvl});
  endtask

  task automatic read_req(input logic lvl);
    send_item('{func: FUNC_READ, pin_level: lvl});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // reads may still sit in the divider after the last expected result
  task automatic settle();
    drain();
    repeat (50) @(negedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ENABLE;
    cfg_wdata_i <= CFG_DATA_BITS'(s.enable);
    @(negedge clk_i);
    cfg_idx_i   <= REG_TICK_DIVIDER;
    cfg_wdata_i <= CFG_DATA_BITS'(s.tick_divider);
    @(negedge clk_i);
    cfg_idx_i   <= REG_PERIOD_LIMIT;
    cfg_wdata_i <= CFG_DATA_BITS'(s.period_limit);
    @(negedge clk_i);
    cfg_idx_i   <= REG_REFERENCE_RATE;
    cfg_wdata_i <= CFG_DATA_BITS'(s.reference_rate);
    @(negedge clk_i);
    cfg_idx_i   <= REG_DUTY_SCALE;
    cfg_wdata_i <= CFG_DATA_BITS'(s.duty_scale);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    active = s;
  endtask

  function automatic cfg_t pick_settings(input int k);
    cfg_t s;
    s.enable         = 1'b1;
    s.tick_divider   = PRE_BITS'($urandom_range(3));
    s.period_limit   = LIMIT_BITS'($urandom_range(2, 40));
    s.reference_rate = RATE_BITS'($urandom_range(24'hFFFFFF));
    s.duty_scale     = SCALE_BITS'($urandom_range(17'h1FFFF));
    case (k)
      0: s = '{enable: 1'b1, tick_divider: '0, period_limit: '1,
               reference_rate: 24'd1000000, duty_scale: 17'd1000};
      1: s = '{enable: 1'b1, tick_divider: 16'd1, period_limit: '1,
               reference_rate: '1, duty_scale: 17'd100000};
      2: s = '{enable: 1'b1, tick_divider: '0, period_limit: '0,
               reference_rate: '0, duty_scale: '1};
      3: s = '{enable: 1'b1, tick_divider: '0, period_limit: 16'd1,
               reference_rate: 24'd1, duty_scale: '0};
      4: s.enable = 1'b0;
      5: begin
        s.tick_divider = '1;
        s.period_limit = LIMIT_BITS'($urandom_range(16'hFFFF));
      end
      7: begin
        s.tick_divider = '0;
        s.period_limit = '1;
        s.duty_scale   = 17'd100000;
      end
      default: ;
    endcase
    return s;
  endfunction

  // mostly whole PWM periods followed by a read, the rest noise, read bursts or a long steady level and a read
  task automatic burst();
    int kind;
    int n;
    int h;
    int l;
    kind = $urandom_range(99);
    if (kind < 65) begin
      n = $urandom_range(1, 3);
      h = $urandom_range(1, 12);
      l = $urandom_range(1, 12);
      repeat (n) begin
        repeat (h) tick(1'b1);
        repeat (l) tick(1'b0);
      end
      if ($urandom_range(1)) tick(1'b1);
      read_req(1'($urandom_range(1)));
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 8)) tick(1'($urandom_range(1)));
    end else if (kind < 92) begin
      repeat ($urandom_range(2, 4)) read_req(1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(20, 80)) tick(kind[0]);
      read_req(1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int budget, input bit hold_mid);
    int  first;
    bit  held;
    first = items_sent;
    held  = 1'b0;
    while (items_sent - first < budget) begin
      if (hold_mid && !held && items_sent - first >= budget / 2) begin
        drain();
        held = 1'b1;
      end
      burst();
    end
  endtask

  initial begin
    cfg_t s;
    active = '{enable: 1'b0, tick_divider: TICK_DIVIDER_RST, period_limit: PERIOD_LIMIT_RST,
               reference_rate: REFERENCE_RATE_RST, duty_scale: DUTY_SCALE_RST};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // disabled after reset: ticks only track the pin, reads report nothing
    tick(1'b1);
    tick(1'b0);
    read_req(1'b1);
    settle();

    s = pick_settings(0);
    load_settings(s);
    read_req(1'b0);
    repeat (2) tick(1'b0);
    tick(1'b1);
    repeat (4) tick(1'b1);
    tick(1'b0);
    repeat (3) tick(1'b0);
    tick(1'b1);
    read_req(1'b1);
    // falling edge with no period captured: duty equals the scale and reports zero
    tick(1'b0);
    read_req(1'b0);

    for (int k = 0; k < 8; k++) begin
      settle();
      load_settings(pick_settings(k));
      calm = (k == 0);
      run_phase(120, k == 6);
    end
    while (reads_live < 60) burst();

    drain();
    repeat (60) @(negedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("pwm_input_capture_measure_tb OK");
    end else begin
      $display("pwm_input_capture_measure_tb NOT OK");
    end
    $finish;
  end

endmodule
